>>> rtl/adfp_pkg.sv
// Package for the ASCII decimal field packet parser.
// Holds the parse mode type, configuration register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package adfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned INDEX_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_HDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END       = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] RANGE_HDR_RST = 8'd65;
	localparam logic [BYTE_W-1:0] CALIB_HDR_RST = 8'd66;
	localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'd44;
	localparam logic [BYTE_W-1:0] END_RST       = 8'd46;

	// ASCII code of the digit zero.
	localparam logic [VALUE_W-1:0] ASCII_ZERO = 32'd48;

	typedef enum logic [1:0] {
		MODE_HUNT  = 2'd0,
		MODE_RANGE = 2'd1,
		MODE_CALIB = 2'd2
	} adfp_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] range_hdr;
		logic [BYTE_W-1:0] calib_hdr;
		logic [BYTE_W-1:0] separator;
		logic [BYTE_W-1:0] end_mark;
	} adfp_cfg_t;

	typedef struct packed {
		logic               emit;
		logic               packet_kind;
		logic [INDEX_W-1:0] field_index;
		logic [VALUE_W-1:0] field_value;
		logic               last_field;
		logic               index_overflow;
	} adfp_res_t;

endpackage

`default_nettype wire

>>> rtl/adfp_cfg.sv
// Configuration register file of the ASCII decimal field packet parser.
// Depends on adfp_pkg for register indexes, reset values and the adfp_cfg_t struct.
`default_nettype none

module adfp_cfg
	import adfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	output adfp_cfg_t                 cfg
);

	adfp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_hdr <= RANGE_HDR_RST;
			cfg_q.calib_hdr <= CALIB_HDR_RST;
			cfg_q.separator <= SEPARATOR_RST;
			cfg_q.end_mark  <= END_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RANGE_HDR: cfg_q.range_hdr <= cfg_data;
				REG_CALIB_HDR: cfg_q.calib_hdr <= cfg_data;
				REG_SEPARATOR: cfg_q.separator <= cfg_data;
				REG_END:       cfg_q.end_mark  <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/adfp_core.sv
// Parse state machine, field counter and decimal accumulator.
// Depends on adfp_pkg; decodes one registered byte per fire and reports a field when one ends.
`default_nettype none

module adfp_core
	import adfp_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire adfp_cfg_t         cfg,
	output adfp_res_t              res
);

	localparam int unsigned CNT_W = $clog2(MAX_FIELDS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELDS);
	localparam logic [CNT_W-1:0] IDX_MAX = CNT_W'(MAX_FIELDS - 1);

	adfp_mode_t          mode_q, mode_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;
	logic [VALUE_W-1:0]  acc_digit;
	logic                cnt_full;
	logic [CNT_W-1:0]    idx_clamped;
	logic [CNT_W+2:0]    idx_ext;
	logic                kind;

	// value*10 + (byte - '0') as two shifted adds; wraps at 32 bits.
	assign acc_digit = (acc_q << 3) + (acc_q << 1)
		+ {{(VALUE_W-BYTE_W){1'b0}}, rx_byte} - ASCII_ZERO;

	assign cnt_full    = (cnt_q >= CNT_MAX);
	assign idx_clamped = cnt_full ? IDX_MAX : cnt_q;
	assign idx_ext     = {3'b000, idx_clamped};
	assign kind        = (mode_q == MODE_CALIB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
		end
	end

	always_comb begin
		mode_d             = mode_q;
		cnt_d              = cnt_q;
		acc_d              = acc_q;
		res.emit           = 1'b0;
		res.packet_kind    = kind;
		res.field_index    = idx_ext[INDEX_W-1:0];
		res.field_value    = acc_q;
		res.last_field     = 1'b0;
		res.index_overflow = cnt_full;
		case (mode_q)
			MODE_RANGE, MODE_CALIB: begin
				if (rx_byte == cfg.end_mark) begin
					res.emit       = 1'b1;
					res.last_field = 1'b1;
					mode_d         = MODE_HUNT;
					cnt_d          = '0;
					acc_d          = '0;
				end else if (!kind && rx_byte == cfg.range_hdr) begin
					// A repeated range header restarts the packet.
					cnt_d = '0;
					acc_d = '0;
				end else if (rx_byte == cfg.separator) begin
					res.emit = 1'b1;
					cnt_d    = cnt_full ? cnt_q : cnt_q + CNT_W'(1);
					acc_d    = '0;
				end else begin
					acc_d = acc_digit;
				end
			end
			default: begin
				// Hunting; the calibration header wins when both headers match.
				mode_d = MODE_HUNT;
				if (rx_byte == cfg.calib_hdr) begin
					mode_d = MODE_CALIB;
					cnt_d  = '0;
					acc_d  = '0;
				end else if (rx_byte == cfg.range_hdr) begin
					mode_d = MODE_RANGE;
					cnt_d  = '0;
					acc_d  = '0;
				end
			end
		endcase
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("field counter ran past its saturation value");

	a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.emit && res.last_field) |=> (mode_q == MODE_HUNT && cnt_q == '0))
		else $error("end byte did not send the parser back to hunting");

	a_hunt_never_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_RANGE && mode_q != MODE_CALIB) |-> !res.emit)
		else $error("field reported while hunting for a header");

endmodule

`default_nettype wire

>>> rtl/ascii_decimal_field_packet_parser_top.sv
// Top level of the ASCII decimal field packet parser.
// Depends on adfp_pkg, adfp_cfg and adfp_core; holds the input and result registers.
//
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-----------------------------------------------
// s_*     | in        | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
// m_*     | out       | m_tvalid/m_tready  | m_tdata: field_index, field_value,
//         |           |                    |   index_overflow; m_tlast: last_field;
//         |           |                    |   m_tuser: packet_kind
// cfg_*   | in        | cfg_wen            | cfg_index selects register, cfg_data value
//
// Each byte is taken into an input register; the multiply-by-ten accumulate and the
// delimiter compares that decode it sit between the input register and the result register.
// A byte can be taken in every cycle while no result is held by a low m_tready, so the block
// sustains one transfer per clock; m_tvalid rises once the byte that ends a field has passed
// both registers. Every byte, whether it ends a field or not, waits in the input register
// while a result is held by a low m_tready, so s_tready drops as soon as that register is
// occupied and stays low until the result leaves. Reset is asynchronous and active low; it
// returns the parser to header hunting and the configuration registers to their defaults.
`default_nettype none

module ascii_decimal_field_packet_parser_top
	import adfp_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [7:0] rx_byte

	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [39:0]               m_tdata,  // [2:0] field_index, [34:3] field_value,
	                                            // [35] index_overflow, [39:36] zero
	output logic                      m_tlast,  // last_field
	output logic                      m_tuser,  // [0] packet_kind

	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	adfp_cfg_t cfg;
	adfp_res_t res;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                fire;

	logic                valid_s2;
	logic                kind_s2;
	logic [INDEX_W-1:0]  index_s2;
	logic [VALUE_W-1:0]  value_s2;
	logic                last_s2;
	logic                ovf_s2;

	adfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The byte in the input register is decoded once the result register can take
	// whatever it produces; a byte that produces nothing is decoded in the same way.
	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	adfp_core #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register: loaded when a decoded byte ends a field, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			kind_s2  <= res.packet_kind;
			index_s2 <= res.field_index;
			value_s2 <= res.field_value;
			last_s2  <= res.last_field;
			ovf_s2   <= res.index_overflow;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, ovf_s2, value_s2, index_s2};
	assign m_tlast  = last_s2;
	assign m_tuser  = kind_s2;

	a_stall_blocks_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |-> !fire)
		else $error("byte decoded while the result register was held");

	a_full_input_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while the pending byte could not be decoded");

	a_ovf_clamps_index: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ovf_s2) |-> (index_s2 == INDEX_W'(MAX_FIELDS - 1)))
		else $error("overflowed field index not clamped to the last position");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for ascii_decimal_field_packet_parser_top.
// It uses adfp_pkg and the RTL only. A built-in decoder model predicts every field, and each
// result transfer is checked against that prediction under random idling and back-pressure.

module testbench;
	import adfp_pkg::*;

	localparam int unsigned FIELD_LIMIT  = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam logic [7:0]  CHAR_ZERO    = 8'h30;

	// One decoded field as it should leave the block.
	typedef struct {
		logic        kind;
		logic [2:0]  index;
		logic [31:0] value;
		logic        last;
		logic        ovf;
	} field_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [39:0]          m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data  = '0;

	// Decoder model state, with its own copy of the delimiter registers.
	adfp_mode_t  dec_mode   = MODE_HUNT;
	logic [3:0]  dec_count  = '0;
	logic [31:0] dec_acc    = '0;
	logic [7:0]  hdr_range  = RANGE_HDR_RST;
	logic [7:0]  hdr_calib  = CALIB_HDR_RST;
	logic [7:0]  sep_code   = SEPARATOR_RST;
	logic [7:0]  end_code   = END_RST;

	field_t      pending_fields[$];
	int unsigned error_count  = 0;
	int unsigned cycle_count  = 0;
	int unsigned bytes_sent   = 0;
	int unsigned burst_left   = 0;
	bit          sender_steady = 1'b0;
	bit          rx_hold       = 1'b0;
	int unsigned rx_left       = 0;
	int unsigned rx_mode       = 0;
	int unsigned rx_phase      = 0;

	ascii_decimal_field_packet_parser_top #(
		.MAX_FIELDS(FIELD_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Any run that outlives the limit is hung or badly stalled, and counts as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Queues the field that the decoder would emit now, with the index clamped once the
	// field count has reached the limit.
	task automatic queue_field(input logic kind, input logic last);
		field_t f;
		f.kind  = kind;
		f.ovf   = (dec_count >= FIELD_LIMIT);
		f.index = f.ovf ? 3'(FIELD_LIMIT - 1) : dec_count[2:0];
		f.value = dec_acc;
		f.last  = last;
		pending_fields.push_back(f);
	endtask

	// Advances the decoder model by one received byte.
	task automatic decode_byte(input logic [7:0] b);
		logic kind;
		if (dec_mode != MODE_RANGE && dec_mode != MODE_CALIB) begin
			// Hunting: only the headers matter, and the calibration header wins a tie.
			dec_mode = MODE_HUNT;
			if (b == hdr_range) begin
				dec_mode  = MODE_RANGE;
				dec_count = '0;
				dec_acc   = '0;
			end
			if (b == hdr_calib) begin
				dec_mode  = MODE_CALIB;
				dec_count = '0;
				dec_acc   = '0;
			end
		end else begin
			kind = (dec_mode == MODE_CALIB);
			if (b == end_code) begin
				queue_field(kind, 1'b1);
				dec_mode  = MODE_HUNT;
				dec_count = '0;
				dec_acc   = '0;
			end else if (!kind && b == hdr_range) begin
				// A repeated range header starts the range packet afresh.
				dec_count = '0;
				dec_acc   = '0;
			end else if (b == sep_code) begin
				queue_field(kind, 1'b0);
				if (dec_count < FIELD_LIMIT)
					dec_count++;
				dec_acc = '0;
			end else begin
				dec_acc = dec_acc * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
			end
		end
	endtask

	// Monitor: register writes, input transfers and result transfers are all sampled at
	// the rising edge, so the values seen are those that the block itself acts on.
	always @(posedge clk) begin
		field_t f;
		if (arst_n) begin
			if (cfg_wen) begin
				case (cfg_index)
				REG_RANGE_HDR: hdr_range = cfg_data;
				REG_CALIB_HDR: hdr_calib = cfg_data;
				REG_SEPARATOR: sep_code  = cfg_data;
				REG_END:       end_code  = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (pending_fields.size() == 0) begin
					$error("unexpected result transfer: field_value %0d",
						$signed(m_tdata[34:3]));
					error_count++;
				end else begin
					f = pending_fields.pop_front();
					if (m_tuser !== f.kind) begin
						$error("packet_kind: expected %0d, got %0d", f.kind, m_tuser);
						error_count++;
					end
					if (m_tdata[2:0] !== f.index) begin
						$error("field_index: expected %0d, got %0d", f.index, m_tdata[2:0]);
						error_count++;
					end
					if (m_tdata[34:3] !== f.value) begin
						$error("field_value: expected %0d, got %0d", $signed(f.value),
							$signed(m_tdata[34:3]));
						error_count++;
					end
					if (m_tlast !== f.last) begin
						$error("last_field: expected %0d, got %0d", f.last, m_tlast);
						error_count++;
					end
					if (m_tdata[35] !== f.ovf) begin
						$error("index_overflow: expected %0d, got %0d", f.ovf, m_tdata[35]);
						error_count++;
					end
				end
			end
		end
	end

	// Receiver: it picks a stall pattern for a random stretch, then another one. A long
	// hold-off requested by a test overrides the pattern.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		rx_phase++;
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_phase % 5) < 3);
			endcase
		end
	end

	// Keeps the receiver from accepting anything for a number of cycles; run as its own
	// process so the sender carries on meanwhile.
	task automatic hold_receiver(input int unsigned cycles);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	// Offers one byte and returns at the falling edge after its transfer, with tvalid still
	// high so that a following byte can go in the very next cycle. Bursts of random length
	// are broken up by random gaps unless the sender is told to stay steady.
	task automatic send_rx_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0 && !sender_steady) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_rx_byte(s[i]);
	endtask

	// Stops offering bytes and waits until every predicted field has come out, then lets
	// the block settle, since a byte in flight may produce nothing.
	task automatic wait_idle();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all_regs(input logic [7:0] rng, input logic [7:0] cal,
			input logic [7:0] sep, input logic [7:0] fin);
		wait_idle();
		write_reg(REG_RANGE_HDR, rng);
		write_reg(REG_CALIB_HDR, cal);
		write_reg(REG_SEPARATOR, sep);
		write_reg(REG_END, fin);
	endtask

	// A delimiter code: often an extreme, sometimes anything, mostly a non-digit byte so
	// that the packets stay well formed.
	function automatic logic [7:0] pick_code();
		logic [7:0] v;
		v = 8'($urandom);
		case ($urandom_range(0, 5))
		0: v = 8'h00;
		1: v = 8'hFF;
		2: ;
		default: begin
			while (v >= CHAR_ZERO && v <= CHAR_ZERO + 8'd9)
				v = 8'($urandom);
		end
		endcase
		return v;
	endfunction

	// A packet with random content under the current delimiters. Now and then a field is
	// long enough to wrap, holds a stray byte, or is restarted by a repeated range header;
	// a few packets overrun the field limit or lose their end byte.
	task automatic send_random_packet(input int unsigned max_fields);
		int unsigned nf;
		int unsigned nd;
		send_rx_byte($urandom_range(0, 1) ? hdr_range : hdr_calib);
		nf = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, max_fields);
		for (int unsigned f = 0; f < nf; f++) begin
			nd = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
			repeat (nd) begin
				if ($urandom_range(0, 19) == 0)
					send_rx_byte(8'($urandom));
				else
					send_rx_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 29) == 0)
				send_rx_byte(hdr_range);
			if (f != nf - 1)
				send_rx_byte(sep_code);
			else if ($urandom_range(0, 11) != 0)
				send_rx_byte(end_code);
		end
		// Line noise between packets.
		repeat ($urandom_range(0, 2))
			send_rx_byte(8'($urandom));
	endtask

	task automatic send_random_until(input int unsigned count);
		int unsigned stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_random_packet(8);
	endtask

	// Default delimiters: ignored bytes while hunting, extreme byte values as digits, an
	// empty field, a header taken as a digit in a calibration packet, a repeated range
	// header and a packet that runs past the field limit.
	task automatic test_default_packets();
		send_text("Z9");
		send_text("A");
		send_rx_byte(8'h00);
		send_rx_byte(8'hFF);
		send_text(",.");
		send_text("B12A.");
		send_text("A5A7.");
		send_text("A,,,,,,,,,.");
	endtask

	// When both header registers hold the same code, that code opens a calibration packet.
	task automatic test_equal_headers();
		write_all_regs(8'h41, 8'h41, SEPARATOR_RST, END_RST);
		send_text("A1,23.A4.");
		send_random_until(20);
	endtask

	// Registers at their extremes, including a separator that equals the calibration
	// header and an end byte that equals the range header.
	task automatic test_extreme_codes();
		write_all_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
		send_random_until(60);
		write_all_regs(8'hFF, 8'h00, 8'h00, 8'hFF);
		send_random_until(60);
	endtask

	task automatic test_random_codes();
		repeat (4) begin
			write_all_regs(pick_code(), pick_code(), pick_code(), pick_code());
			send_random_until(90);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering transfers
	// without gaps, so the block fills up and must stall its input.
	task automatic test_backpressure();
		write_all_regs(RANGE_HDR_RST, CALIB_HDR_RST, SEPARATOR_RST, END_RST);
		sender_steady = 1'b1;
		fork
			hold_receiver(300);
		join_none
		send_text("A1,2,3,4,5,6,7.B8,9.");
		send_random_until(100);
		sender_steady = 1'b0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_packets();
		test_equal_headers();
		test_extreme_codes();
		test_random_codes();
		test_backpressure();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_fields.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
